/* rtl/dnsq_pkg.sv */
// Shared types and constants for the DNS query name extractor.
// Used by every module of the block; depends on nothing else.
package dnsq_pkg;

    // Field widths fixed by the result format.
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 6;
    localparam int QTYPE_W = 16;
    localparam int PORT_W  = 16;

    // Reset value of the DNS port register.
    localparam logic [PORT_W-1:0] DNS_PORT_RESET = 16'd53;

    // Header masks.
    localparam logic [15:0] FRAG_MASK = 16'h1fff;
    localparam logic [15:0] QR_MASK   = 16'h8000;
    localparam logic [7:0]  IHL_MASK  = 8'h0f;

    // IP header fields.
    localparam logic [3:0] IP_VER4     = 4'd4;
    localparam logic [3:0] IP_VER6     = 4'd6;
    localparam logic [3:0] IHL_MIN     = 4'd5;
    localparam logic [5:0] V6_HDR_LEN  = 6'd40;
    localparam logic [7:0] PROTO_UDP   = 8'd17;
    localparam logic [7:0] OFF_FRAG_HI = 8'd6;
    localparam logic [7:0] OFF_FRAG_LO = 8'd7;
    localparam logic [7:0] OFF_V4_PROTO = 8'd9;
    localparam logic [7:0] OFF_V6_NEXT  = 8'd6;
    localparam logic [7:0] OFF_MAX      = 8'd255;

    // Offsets relative to the start of the UDP header.
    localparam logic [7:0] REL_PORT_HI  = 8'd2;
    localparam logic [7:0] REL_PORT_LO  = 8'd3;
    localparam logic [7:0] REL_FLAGS_HI = 8'd10;
    localparam logic [7:0] REL_QD_HI    = 8'd12;
    localparam logic [7:0] REL_QD_LO    = 8'd13;
    localparam logic [7:0] UDP_DNS_HDR  = 8'd20;

    // Hard ceiling on stored name bytes.
    localparam logic [LEN_W-1:0] NAME_CEIL = 6'd62;

    // Request from the parser to start a result burst.
    typedef struct packed {
        logic               valid;
        logic [LEN_W-1:0]   len;
        logic [QTYPE_W-1:0] qtype;
    } emit_req_t;

    // Result burst sequencer states.
    typedef enum logic [1:0] {
        EM_IDLE,
        EM_NAME,
        EM_FINAL
    } emit_state_t;

endpackage

/* rtl/dnsq_name_ram.sv */
// Name byte store: one write port, one registered read port.
// Depends on dnsq_pkg for the byte width.
module dnsq_name_ram
    import dnsq_pkg::*;
#(
    parameter int DEPTH = 63,
    parameter int AW    = 6
)(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [BYTE_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [BYTE_W-1:0] rd_data
);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/dnsq_parser.sv */
// Per-byte header parser: tracks packet offset, runs the IP, UDP and DNS
// checks, writes name bytes into the store and requests the result burst.
// Depends on dnsq_pkg.
module dnsq_parser
    import dnsq_pkg::*;
#(
    parameter int NAME_MAX = 63,
    parameter int AW       = 6
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              packet_end,
    input  logic              cgroup_selected,
    input  logic [PORT_W-1:0] dns_port,
    output logic              wr_en,
    output logic [AW-1:0]     wr_addr,
    output logic [BYTE_W-1:0] wr_data,
    output emit_req_t         emit_req
);

    logic [7:0]        offset_reg, offset_next;
    logic              is_v6_reg, is_v6_next;
    logic [5:0]        hdr_len_reg, hdr_len_next;
    logic              dropped_reg, dropped_next;
    logic              finished_reg, finished_next;
    logic [LEN_W-1:0]  count_reg, count_next;
    logic [BYTE_W-1:0] high_reg, high_next;

    logic [7:0]  rel;
    logic [7:0]  qpos;
    logic [6:0]  count_plus1;
    logic        name_full;

    assign rel         = offset_reg - {2'b00, hdr_len_reg};
    assign qpos        = rel - UDP_DNS_HDR;
    assign count_plus1 = {1'b0, count_reg} + 7'd1;
    assign name_full   = (count_plus1 >= 7'(NAME_MAX)) || (count_reg >= NAME_CEIL);

    // Byte handling and next-state of the packet state.
    always_comb
    begin
        offset_next   = offset_reg;
        is_v6_next    = is_v6_reg;
        hdr_len_next  = hdr_len_reg;
        dropped_next  = dropped_reg;
        finished_next = finished_reg;
        count_next    = count_reg;
        high_next     = high_reg;
        wr_en         = 1'b0;
        wr_addr       = count_reg[AW-1:0];
        wr_data       = data_byte;
        emit_req      = '0;

        if (accept)
        begin
            if (!dropped_reg && !finished_reg)
            begin
                if (offset_reg == 8'd0)
                begin
                    // First byte: watched sender and IP version.
                    if (!cgroup_selected)
                    begin
                        dropped_next = 1'b1;
                    end
                    else if (data_byte[7:4] == IP_VER4)
                    begin
                        if ((data_byte & IHL_MASK) < {4'd0, IHL_MIN})
                        begin
                            dropped_next = 1'b1;
                        end
                        else
                        begin
                            hdr_len_next = {data_byte[3:0], 2'b00};
                            is_v6_next   = 1'b0;
                        end
                    end
                    else if (data_byte[7:4] == IP_VER6)
                    begin
                        hdr_len_next = V6_HDR_LEN;
                        is_v6_next   = 1'b1;
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                end
                else if (offset_reg < {2'b00, hdr_len_reg})
                begin
                    // Rest of the IP header.
                    if (is_v6_reg)
                    begin
                        if (offset_reg == OFF_V6_NEXT && data_byte != PROTO_UDP)
                        begin
                            dropped_next = 1'b1;
                        end
                    end
                    else
                    begin
                        if (offset_reg == OFF_FRAG_HI
                            && (data_byte & FRAG_MASK[15:8]) != 8'd0)
                        begin
                            dropped_next = 1'b1;
                        end
                        if (offset_reg == OFF_FRAG_LO
                            && (data_byte & FRAG_MASK[7:0]) != 8'd0)
                        begin
                            dropped_next = 1'b1;
                        end
                        if (offset_reg == OFF_V4_PROTO && data_byte != PROTO_UDP)
                        begin
                            dropped_next = 1'b1;
                        end
                    end
                end
                else
                begin
                    // UDP header, DNS header and question.
                    if (rel == REL_PORT_HI || rel == REL_QD_HI)
                    begin
                        high_next = data_byte;
                    end
                    else if (rel == REL_PORT_LO)
                    begin
                        if ({high_reg, data_byte} != dns_port)
                        begin
                            dropped_next = 1'b1;
                        end
                    end
                    else if (rel == REL_FLAGS_HI)
                    begin
                        if (({data_byte, 8'h00} & QR_MASK) != 16'd0)
                        begin
                            dropped_next = 1'b1;
                        end
                    end
                    else if (rel == REL_QD_LO)
                    begin
                        if (high_reg == 8'd0 && data_byte == 8'd0)
                        begin
                            dropped_next = 1'b1;
                        end
                    end
                    else if (rel >= UDP_DNS_HDR)
                    begin
                        if (qpos == {2'b00, count_reg})
                        begin
                            if (data_byte != 8'd0)
                            begin
                                if (name_full)
                                begin
                                    dropped_next = 1'b1;
                                end
                                else
                                begin
                                    wr_en      = 1'b1;
                                    count_next = count_plus1[LEN_W-1:0];
                                end
                            end
                        end
                        else if (qpos == {1'b0, count_plus1})
                        begin
                            high_next = data_byte;
                        end
                        else if (qpos == {1'b0, count_plus1} + 8'd1)
                        begin
                            emit_req.valid = 1'b1;
                            emit_req.len   = (count_reg > NAME_CEIL) ? NAME_CEIL : count_reg;
                            emit_req.qtype = {high_reg, data_byte};
                            finished_next  = 1'b1;
                        end
                    end
                end

                // Advance while the packet is still live.
                if (!dropped_next && !finished_next && offset_reg != OFF_MAX)
                begin
                    offset_next = offset_reg + 8'd1;
                end
            end

            // End of packet returns all per-packet state to reset.
            if (packet_end)
            begin
                offset_next   = '0;
                is_v6_next    = 1'b0;
                hdr_len_next  = '0;
                dropped_next  = 1'b0;
                finished_next = 1'b0;
                count_next    = '0;
                high_next     = '0;
            end
        end
    end

    // Packet state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg   <= '0;
            is_v6_reg    <= 1'b0;
            hdr_len_reg  <= '0;
            dropped_reg  <= 1'b0;
            finished_reg <= 1'b0;
            count_reg    <= '0;
            high_reg     <= '0;
        end
        else
        begin
            offset_reg   <= offset_next;
            is_v6_reg    <= is_v6_next;
            hdr_len_reg  <= hdr_len_next;
            dropped_reg  <= dropped_next;
            finished_reg <= finished_next;
            count_reg    <= count_next;
            high_reg     <= high_next;
        end
    end

endmodule

/* rtl/dnsq_emit.sv */
// Result burst sequencer: reads the stored name back one entry at a time
// into the output register, then sends the final item carrying the type.
// Depends on dnsq_pkg.
module dnsq_emit
    import dnsq_pkg::*;
#(
    parameter int AW = 6
)(
    input  logic               clk,
    input  logic               rst_n,
    input  emit_req_t          emit_req,
    output logic               busy,
    output logic               rd_en,
    output logic [AW-1:0]      rd_addr,
    input  logic [BYTE_W-1:0]  rd_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [BYTE_W-1:0]  out_byte,
    output logic [LEN_W-1:0]   out_index,
    output logic [LEN_W-1:0]   out_len,
    output logic [QTYPE_W-1:0] out_qtype,
    output logic               out_last
);

    emit_state_t state_reg, state_next;

    logic [LEN_W-1:0]   idx_reg, idx_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [QTYPE_W-1:0] qtype_reg, qtype_next;
    logic               pend_reg, pend_next;
    logic [LEN_W-1:0]   pend_idx_reg, pend_idx_next;

    logic               ovalid_reg, ovalid_next;
    logic [BYTE_W-1:0]  obyte_reg, obyte_next;
    logic [LEN_W-1:0]   oindex_reg, oindex_next;
    logic [LEN_W-1:0]   olen_reg, olen_next;
    logic [QTYPE_W-1:0] oqtype_reg, oqtype_next;
    logic               olast_reg, olast_next;

    logic out_free;
    logic issue;

    assign out_free = !ovalid_reg || out_ready;
    assign issue    = (state_reg == EM_NAME) && !pend_reg && out_free
                      && (idx_reg < len_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            EM_IDLE:
            begin
                if (emit_req.valid)
                begin
                    state_next = (emit_req.len == '0) ? EM_FINAL : EM_NAME;
                end
            end
            EM_NAME:
            begin
                if (!pend_reg && idx_reg == len_reg)
                begin
                    state_next = EM_FINAL;
                end
            end
            EM_FINAL:
            begin
                if (out_free)
                begin
                    state_next = EM_IDLE;
                end
            end
            default:
            begin
                state_next = EM_IDLE;
            end
        endcase
    end

    // Burst counters, memory reads and the output register.
    always_comb
    begin
        idx_next      = idx_reg;
        len_next      = len_reg;
        qtype_next    = qtype_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        ovalid_next   = ovalid_reg && !out_ready;
        obyte_next    = obyte_reg;
        oindex_next   = oindex_reg;
        olen_next     = olen_reg;
        oqtype_next   = oqtype_reg;
        olast_next    = olast_reg;
        rd_en         = issue;
        rd_addr       = idx_reg[AW-1:0];

        if (state_reg == EM_IDLE && emit_req.valid)
        begin
            idx_next   = '0;
            len_next   = emit_req.len;
            qtype_next = emit_req.qtype;
        end

        // Start a read; its data passes through the store's read register, then lands in the output register.
        if (issue)
        begin
            pend_next     = 1'b1;
            pend_idx_next = idx_reg;
            idx_next      = idx_reg + 6'd1;
        end

        if (pend_reg)
        begin
            ovalid_next = 1'b1;
            obyte_next  = rd_data;
            oindex_next = pend_idx_reg;
            olen_next   = len_reg;
            oqtype_next = '0;
            olast_next  = 1'b0;
        end

        if (state_reg == EM_FINAL && out_free)
        begin
            ovalid_next = 1'b1;
            obyte_next  = '0;
            oindex_next = '0;
            olen_next   = len_reg;
            oqtype_next = qtype_reg;
            olast_next  = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= EM_IDLE;
            pend_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
            idx_reg    <= '0;
            len_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            pend_reg   <= pend_next;
            ovalid_reg <= ovalid_next;
            idx_reg    <= idx_next;
            len_reg    <= len_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        qtype_reg    <= qtype_next;
        pend_idx_reg <= pend_idx_next;
        obyte_reg    <= obyte_next;
        oindex_reg   <= oindex_next;
        olen_reg     <= olen_next;
        oqtype_reg   <= oqtype_next;
        olast_reg    <= olast_next;
    end

    assign busy      = (state_reg != EM_IDLE);
    assign out_valid = ovalid_reg;
    assign out_byte  = obyte_reg;
    assign out_index = oindex_reg;
    assign out_len   = olen_reg;
    assign out_qtype = oqtype_reg;
    assign out_last  = olast_reg;

`ifndef NO_ASSERTIONS
    // Read data only lands when the output register is empty.
    assert property (@(posedge clk) disable iff (!rst_n) pend_reg |-> !ovalid_reg)
        else $error("name read landed on an occupied output register");

    // The read index never runs past the burst length.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == EM_NAME |-> idx_reg <= len_reg)
        else $error("burst read index ran past name length");

    // A new burst is only requested while the sequencer is idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        emit_req.valid |-> state_reg == EM_IDLE)
        else $error("burst requested while a burst is in progress");

    // Every issued read is pending in the cycle after it was issued.
    assert property (@(posedge clk) disable iff (!rst_n) issue |=> pend_reg)
        else $error("issued name read did not become pending");
`endif

endmodule

/* rtl/dns_query_name_extractor_core.sv */
// Usage:
// Packet bytes enter on the s_* stream, starting at the IP header, one item
// per byte; s_tlast marks the final byte and s_tuser carries the watched
// sender flag, sampled on the first byte. Qualifying DNS queries yield one
// m_* item per question-name byte, then a final item with m_tlast high that
// carries the question type. Failed checks and short packets yield nothing.
// Throughput: one byte per cycle while parsing. When the second type byte
// is taken, s_tready drops while the name is read back from the name store
// one entry at a time through its registered read port; a new read starts
// only once the last one has reached the output register. The final item
// can still wait in the output register while new bytes are taken. A
// stalled m_tready holds the output register and pauses the read-back.
// cfg_data sets the DNS destination port; write it only while idle.
// Reset (rst_n low) clears the packet state and sets the port to 53; the
// name store needs no clearing pass.
// Depends on dnsq_pkg, dnsq_name_ram, dnsq_parser and dnsq_emit.
module dns_query_name_extractor_core
    import dnsq_pkg::*;
#(
    parameter int NAME_MAX = 63
)(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,     // dns_port
    // Packet byte input.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // data_byte[7:0]
    input  logic        s_tlast,      // packet_end
    input  logic        s_tuser,      // cgroup_selected
    // Result output.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,      // name_byte[7:0], name_index[13:8],
                                      // qname_len[19:14], qtype[35:20], zeros
    output logic        m_tlast       // last
);

    localparam int AW = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;

    logic [PORT_W-1:0] port_reg;
    logic              busy;
    logic              accept;
    emit_req_t         emit_req;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [BYTE_W-1:0] rd_data;

    logic [BYTE_W-1:0]  out_byte;
    logic [LEN_W-1:0]   out_index;
    logic [LEN_W-1:0]   out_len;
    logic [QTYPE_W-1:0] out_qtype;

    // DNS port register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_reg <= DNS_PORT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            port_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = !busy;
    assign accept    = s_tvalid && s_tready;

    dnsq_parser #(
        .NAME_MAX (NAME_MAX),
        .AW       (AW)
    ) u_parser (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .data_byte       (s_tdata),
        .packet_end      (s_tlast),
        .cgroup_selected (s_tuser),
        .dns_port        (port_reg),
        .wr_en           (wr_en),
        .wr_addr         (wr_addr),
        .wr_data         (wr_data),
        .emit_req        (emit_req)
    );

    dnsq_name_ram #(
        .DEPTH (NAME_MAX),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    dnsq_emit #(
        .AW (AW)
    ) u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .emit_req  (emit_req),
        .busy      (busy),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (out_byte),
        .out_index (out_index),
        .out_len   (out_len),
        .out_qtype (out_qtype),
        .out_last  (m_tlast)
    );

    assign m_tdata = {4'd0, out_qtype, out_len, out_index, out_byte};

endmodule
